>>> rtl/core/hth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hth_pkg
// Shared widths, operation and status codes, and the command and status
// structs that join the hash table controller and datapath.
// ----------------------------------------------------------------------------
package hth_pkg;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 31;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int DIV_W     = 32;
    localparam int MOD_BITS  = 4;
    localparam int MOD_SEL_W = 2;
    localparam int MOD_CNT_W = 3;
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 2'd2;

    typedef enum logic [2:0] {
        RES_NONE     = 3'd0,
        RES_ZERO_KEY = 3'd1,
        RES_INS_OK   = 3'd2,
        RES_FULL     = 3'd3,
        RES_LOOKUP   = 3'd4,
        RES_READ     = 3'd5
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      mod_step;
        logic      probe;
        logic      scan;
        logic      read;
        logic      finish;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] req_func;
        logic              req_key_zero;
        logic              clr_last;
        logic              mod_last;
        logic              probe_hit;
        logic              probe_full;
        logic              scan_done;
        logic              out_busy;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/hth_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hth_if
// Request and response channels of the hash table: valid, ready and the
// payload of one request or one result.
// ----------------------------------------------------------------------------
interface hth_req_if;
    logic                        valid;
    logic                        ready;
    logic [hth_pkg::FUNC_W-1:0]  func;
    logic [hth_pkg::KEY_W-1:0]   key;
    logic [hth_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output func, output key, output slot, input ready);
    modport sink   (input valid, input func, input key, input slot, output ready);
endinterface

interface hth_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hth_pkg::STATUS_W-1:0] status;
    logic [hth_pkg::IDX_W-1:0]    where_index;
    logic                         found;
    logic [hth_pkg::COUNT_W-1:0]  match_count;
    logic [hth_pkg::KEY_W-1:0]    slot_value;

    modport source (output valid, output status, output where_index, output found,
                    output match_count, output slot_value, input ready);
    modport sink   (input valid, input status, input where_index, input found,
                    input match_count, input slot_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hth_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hth_ctrl
// Sequencer of the hash table: clearing pass, operation decode, remainder,
// probe, scan and read phases, and result hand-off.
// ----------------------------------------------------------------------------
module hth_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire hth_pkg::sts_t sts,
    output hth_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    hth_pkg::res_kind_t kind_reg;
    hth_pkg::res_kind_t kind_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
                if (req_valid)
                begin
                    priority if (sts.req_func == hth_pkg::FN_INSERT && !sts.req_key_zero)
                    begin
                        state_next = S_MOD;
                    end
                    else if (sts.req_func == hth_pkg::FN_LOOKUP && !sts.req_key_zero)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (sts.req_func == hth_pkg::FN_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (sts.req_func == hth_pkg::FN_INSERT ||
                             sts.req_func == hth_pkg::FN_LOOKUP)
                    begin
                        kind_next  = hth_pkg::RES_ZERO_KEY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        kind_next  = hth_pkg::RES_NONE;
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                priority if (sts.probe_hit)
                begin
                    kind_next  = hth_pkg::RES_INS_OK;
                    state_next = S_DONE;
                end
                else if (sts.probe_full)
                begin
                    kind_next  = hth_pkg::RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    kind_next  = hth_pkg::RES_LOOKUP;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                kind_next  = hth_pkg::RES_READ;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= hth_pkg::RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/hth_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hth_dpath
// Datapath of the hash table: slot memory, four-bit-per-cycle weighted
// remainder unit, probe and scan address walk, match counting and the
// result register.
// ----------------------------------------------------------------------------
module hth_dpath #(
    parameter int TABLE_SIZE   = 16,
    parameter int STEP_MODULUS = 7
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hth_pkg::cmd_t                cmd,
    output hth_pkg::sts_t                     sts,
    input  wire logic [hth_pkg::FUNC_W-1:0]   req_func,
    input  wire logic [hth_pkg::KEY_W-1:0]    req_key,
    input  wire logic [hth_pkg::SLOT_W-1:0]   req_slot,
    input  wire logic                         rsp_ready,
    output logic                              rsp_valid,
    output logic [hth_pkg::STATUS_W-1:0]      rsp_status,
    output logic [hth_pkg::IDX_W-1:0]         rsp_where_index,
    output logic                              rsp_found,
    output logic [hth_pkg::COUNT_W-1:0]       rsp_match_count,
    output logic [hth_pkg::KEY_W-1:0]         rsp_slot_value
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int HW  = IW + 1;
    localparam int KW  = $clog2(STEP_MODULUS);
    localparam int SHW = $clog2((hth_pkg::MOD_BITS + 1) * TABLE_SIZE);
    localparam int SKW = $clog2((hth_pkg::MOD_BITS + 1) * STEP_MODULUS);
    localparam int RED = $clog2(hth_pkg::MOD_BITS);
    localparam int CW  = $clog2(TABLE_SIZE + 1);

    logic [hth_pkg::KEY_W-1:0]     mem [TABLE_SIZE];
    logic [hth_pkg::KEY_W-1:0]     rdata_reg;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [hth_pkg::KEY_W-1:0]     mem_wdata;
    logic                          mem_re;
    logic [IW-1:0]                 mem_raddr;

    logic [hth_pkg::KEY_W-1:0]     key_reg;
    logic [hth_pkg::SLOT_W-1:0]    slot_reg;
    logic                          slot_ok_reg;
    logic [hth_pkg::DIV_W-1:0]     shr_reg;
    logic [IW-1:0]                 rh_reg;
    logic [KW-1:0]                 rk_reg;
    logic [hth_pkg::MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IW-1:0]                 pos_reg;
    logic [CW-1:0]                 probe_cnt_reg;
    logic                          chk_vld_reg;
    logic [IW-1:0]                 chk_pos_reg;
    logic [hth_pkg::IDX_W-1:0]     where_reg;
    logic [hth_pkg::COUNT_W-1:0]   mcnt_reg;
    logic                          out_vld_reg;

    logic [SHW-1:0]                rh_t;
    logic [SKW-1:0]                rk_t;
    logic [IW-1:0]                 wt_h [hth_pkg::DIV_W];
    logic [KW-1:0]                 wt_k [hth_pkg::DIV_W];
    logic [IW-1:0]                 step_tab [STEP_MODULUS];
    logic [IW-1:0]                 pos_inc;
    logic [HW-1:0]                 pos_sum;
    logic [IW-1:0]                 pos_adv;
    logic                          issue;
    logic                          walk;
    logic                          hit;
    logic                          match;

    for (genvar g = 0; g < STEP_MODULUS; g++)
    begin : g_step
        assign step_tab[g] = IW'((STEP_MODULUS - g) % TABLE_SIZE);
    end

    for (genvar g = 0; g < hth_pkg::DIV_W; g++)
    begin : g_wt
        assign wt_h[g] = IW'((64'd1 << g) % TABLE_SIZE);
        assign wt_k[g] = KW'((64'd1 << g) % STEP_MODULUS);
    end

    always_comb
    begin
        rh_t = SHW'(rh_reg);
        rk_t = SKW'(rk_reg);
        for (int b = 0; b < hth_pkg::MOD_BITS; b++)
        begin
            if (shr_reg[b])
            begin
                rh_t = rh_t + SHW'(wt_h[{mod_cnt_reg, hth_pkg::MOD_SEL_W'(b)}]);
                rk_t = rk_t + SKW'(wt_k[{mod_cnt_reg, hth_pkg::MOD_SEL_W'(b)}]);
            end
        end
        for (int k = RED; k >= 0; k--)
        begin
            if (rh_t >= SHW'(TABLE_SIZE << k))
            begin
                rh_t = rh_t - SHW'(TABLE_SIZE << k);
            end
            if (rk_t >= SKW'(STEP_MODULUS << k))
            begin
                rk_t = rk_t - SKW'(STEP_MODULUS << k);
            end
        end
    end

    always_comb
    begin
        walk    = cmd.probe || cmd.scan;
        pos_inc = cmd.scan ? IW'(1) : step_tab[rk_reg];
        pos_sum = {1'b0, pos_reg} + {1'b0, pos_inc};
        if (pos_sum >= HW'(TABLE_SIZE))
        begin
            pos_sum = pos_sum - HW'(TABLE_SIZE);
        end
        pos_adv = pos_sum[IW-1:0];
        issue   = walk && (probe_cnt_reg != CW'(TABLE_SIZE));
        hit     = cmd.probe && chk_vld_reg && (rdata_reg == '0);
        match   = cmd.scan && chk_vld_reg && (rdata_reg == key_reg);
    end

    always_comb
    begin
        mem_we    = cmd.clear || hit;
        mem_waddr = cmd.clear ? pos_reg : chk_pos_reg;
        mem_wdata = cmd.clear ? '0 : key_reg;
        mem_re    = issue || cmd.read;
        mem_raddr = cmd.read ? IW'(slot_reg) : pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        sts.req_func     = req_func;
        sts.req_key_zero = (req_key == '0);
        sts.clr_last     = (pos_reg == IW'(TABLE_SIZE - 1));
        sts.mod_last     = (mod_cnt_reg == hth_pkg::MOD_LAST);
        sts.probe_hit    = hit;
        sts.probe_full   = !hit && (probe_cnt_reg == CW'(TABLE_SIZE));
        sts.scan_done    = !chk_vld_reg && (probe_cnt_reg == CW'(TABLE_SIZE));
        sts.out_busy     = out_vld_reg && !rsp_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            probe_cnt_reg <= '0;
            chk_vld_reg   <= 1'b0;
            mod_cnt_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= issue;
            if (cmd.clear)
            begin
                pos_reg <= sts.clr_last ? '0 : pos_reg + IW'(1);
            end
            else if (cmd.load)
            begin
                pos_reg       <= '0;
                probe_cnt_reg <= '0;
                mod_cnt_reg   <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + hth_pkg::MOD_CNT_W'(1);
                if (sts.mod_last)
                begin
                    pos_reg <= rh_t[IW-1:0];
                end
            end
            else if (issue)
            begin
                pos_reg       <= pos_adv;
                probe_cnt_reg <= probe_cnt_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= req_key;
            slot_reg  <= req_slot;
            shr_reg   <= {1'b0, req_key};
            rh_reg    <= '0;
            rk_reg    <= '0;
            where_reg <= '0;
            mcnt_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            shr_reg <= shr_reg >> hth_pkg::MOD_BITS;
            rh_reg  <= rh_t[IW-1:0];
            rk_reg  <= rk_t[KW-1:0];
        end
        if (issue)
        begin
            chk_pos_reg <= pos_reg;
        end
        if (hit)
        begin
            where_reg <= hth_pkg::IDX_W'(chk_pos_reg);
        end
        if (match)
        begin
            if (mcnt_reg == '0)
            begin
                where_reg <= hth_pkg::IDX_W'(chk_pos_reg);
            end
            if (mcnt_reg != hth_pkg::COUNT_MAX)
            begin
                mcnt_reg <= mcnt_reg + hth_pkg::COUNT_W'(1);
            end
        end
        if (cmd.read)
        begin
            slot_ok_reg <= (32'(slot_reg) < TABLE_SIZE);
        end
        if (cmd.finish)
        begin
            rsp_status      <= hth_pkg::ST_OK;
            rsp_where_index <= '0;
            rsp_found       <= 1'b0;
            rsp_match_count <= '0;
            rsp_slot_value  <= '0;
            unique case (cmd.kind)
                hth_pkg::RES_NONE:
                begin
                    rsp_status <= hth_pkg::ST_OK;
                end
                hth_pkg::RES_ZERO_KEY:
                begin
                    rsp_status <= hth_pkg::ST_ZERO_KEY;
                end
                hth_pkg::RES_INS_OK:
                begin
                    rsp_where_index <= where_reg;
                end
                hth_pkg::RES_FULL:
                begin
                    rsp_status <= hth_pkg::ST_FULL;
                end
                hth_pkg::RES_LOOKUP:
                begin
                    rsp_where_index <= where_reg;
                    rsp_found       <= (mcnt_reg != '0);
                    rsp_match_count <= mcnt_reg;
                end
                hth_pkg::RES_READ:
                begin
                    rsp_slot_value <= slot_ok_reg ? rdata_reg : '0;
                end
                default:
                begin
                    rsp_status <= hth_pkg::ST_OK;
                end
            endcase
        end
    end

    assign rsp_valid = out_vld_reg;

endmodule
`default_nettype wire

>>> rtl/core/hash_table_double_hashing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_table_double_hashing
// Open-addressing hash table with double hashing: insert, lookup and slot
// read over a request/response channel pair.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to zero, one slot a cycle, so
// it takes no request until the sweep is done. Requests are handled one at a
// time and the result sits in an output register, so the next request is
// taken as soon as the block is idle. A read passes through the read and done
// states before its result is registered, and a rejected or unused request
// goes straight to the done state. A lookup walks every slot through the
// memory read port. An insert first reduces the key by TABLE_SIZE and
// STEP_MODULUS four bits a cycle, then probes one slot a cycle with the read
// data registered, with at most TABLE_SIZE probes.
module hash_table_double_hashing #(
    parameter int TABLE_SIZE   = 16,
    parameter int STEP_MODULUS = 7
) (
    input wire logic clk,
    input wire logic rst_n,
    hth_req_if.sink  req,
    hth_rsp_if.source rsp
);

    hth_pkg::cmd_t cmd;
    hth_pkg::sts_t sts;

    hth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hth_dpath #(
        .TABLE_SIZE   (TABLE_SIZE),
        .STEP_MODULUS (STEP_MODULUS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_func        (req.func),
        .req_key         (req.key),
        .req_slot        (req.slot),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_where_index (rsp.where_index),
        .rsp_found       (rsp.found),
        .rsp_match_count (rsp.match_count),
        .rsp_slot_value  (rsp.slot_value)
    );

endmodule
`default_nettype wire
